[rtl/plid_pkg.sv]
// Shared types, constants and handshake structs for the positional list block.
`timescale 1ns / 1ps
`default_nettype none

package plid_pkg;

    localparam int CAPACITY  = 64;
    localparam int WORD_BITS = 32;

    localparam int POS_W = 7;
    localparam int LEN_W = 7;
    localparam int VAL_W = 32;

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MOVE,
        S_DRAIN,
        S_PLACE,
        S_RDWAIT
    } t_state;

    typedef struct packed {
        logic [1:0]              cmd;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] read_value;
        logic [LEN_W-1:0]        list_length;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    init;
        logic    step;
        logic    place;
        logic    rd_issue;
        logic    finish;
        logic    count_inc;
        logic    count_dec;
        logic    fin_read;
        t_status fin_status;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd cmd;
        logic ins_ok;
        logic acc_ok;
        logic full;
        logic no_move_ins;
        logic no_move_del;
        logic last;
    } t_dp_stat;

endpackage

`default_nettype wire

[rtl/plid_dpath.sv]
// Datapath: entry memory, length count, move pointer and result registers.
`timescale 1ns / 1ps
`default_nettype none

module plid_dpath import plid_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_item  i_item,
    input  wire t_ctl_cmd  i_ctl,
    output t_dp_stat       o_stat,
    output logic           o_done,
    output t_out_item      o_result
);

    logic [WORD_BITS-1:0] mem [CAPACITY];

    t_in_item             r_item;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [AW-1:0]        r_ptr;
    logic [AW-1:0]        n_ptr;
    logic                 r_pend;
    logic [AW-1:0]        r_pend_addr;
    logic [WORD_BITS-1:0] r_rdata;
    logic                 r_done;
    t_out_item            r_result;

    t_cmd                 w_cmd;
    logic                 w_is_ins;
    logic [CMP_W-1:0]     w_pos;
    logic [CMP_W-1:0]     w_cnt;
    logic [CMP_W-1:0]     w_pos_m1;
    logic [CMP_W-1:0]     w_cnt_m1;
    logic [AW-1:0]        w_rd_addr;
    logic                 w_rd_en;
    logic [63:0]          w_ext;
    logic [63:0]          w_rext;

    always_comb begin
        w_cmd    = t_cmd'(r_item.cmd);
        w_is_ins = (w_cmd == CMD_INSERT);
        w_pos    = CMP_W'(r_item.position);
        w_cnt    = CMP_W'(r_count);
        w_pos_m1 = w_pos - CMP_W'(1);
        w_cnt_m1 = w_cnt - CMP_W'(1);

        o_stat.cmd         = w_cmd;
        o_stat.ins_ok      = (w_pos != '0) && (w_pos <= w_cnt + CMP_W'(1));
        o_stat.acc_ok      = (w_pos != '0) && (w_pos <= w_cnt);
        o_stat.full        = (w_cnt >= CMP_W'(CAPACITY));
        o_stat.no_move_ins = (w_pos == w_cnt + CMP_W'(1));
        o_stat.no_move_del = (w_pos == w_cnt);
        o_stat.last        = w_is_ins ? (r_ptr == AW'(w_pos_m1)) : (r_ptr == AW'(w_cnt_m1));

        w_rd_addr = i_ctl.rd_issue ? AW'(w_pos_m1) : r_ptr;
        w_rd_en   = i_ctl.step | i_ctl.rd_issue;

        // Inserts walk the pointer down from the tail, deletes walk it up.
        n_ptr = r_ptr;
        if (i_ctl.init) begin
            n_ptr = w_is_ins ? AW'(w_cnt_m1) : AW'(w_pos);
        end else if (i_ctl.step) begin
            n_ptr = w_is_ins ? r_ptr - AW'(1) : r_ptr + AW'(1);
        end

        n_count = r_count;
        if (i_ctl.finish && i_ctl.count_inc) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_ctl.finish && i_ctl.count_dec) begin
            n_count = r_count - CNT_W'(1);
        end

        w_ext  = {{(64 - VAL_W){r_item.value[VAL_W-1]}}, r_item.value};
        w_rext = 64'($signed(r_rdata));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_pend  <= i_ctl.step;
            r_done  <= i_ctl.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_item <= i_item;
        end
        r_ptr <= n_ptr;
        if (i_ctl.step) begin
            r_pend_addr <= w_is_ins ? r_ptr + AW'(1) : r_ptr - AW'(1);
        end
        if (i_ctl.finish) begin
            r_result.status      <= i_ctl.fin_status;
            r_result.read_value  <= i_ctl.fin_read ? w_rext[VAL_W-1:0] : '0;
            r_result.list_length <= LEN_W'(n_count);
        end
    end

    // One write port: a moved word is written from its registered read data, the new word last.
    always_ff @(posedge i_clk) begin
        if (i_ctl.place) begin
            mem[AW'(w_pos_m1)] <= w_ext[WORD_BITS-1:0];
        end else if (r_pend) begin
            mem[r_pend_addr] <= r_rdata;
        end
        if (w_rd_en) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_count) <= CNT_W'(CAPACITY))
        else $error("list length beyond capacity");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe held for two cycles");

    a_place_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.place |-> !r_pend)
        else $error("new word written while a move is still pending");

endmodule

`default_nettype wire

[rtl/plid_ctrl.sv]
// Controller state machine that sequences decode, shifting moves and result beats.
`timescale 1ns / 1ps
`default_nettype none

module plid_ctrl import plid_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_dp_stat i_stat,
    output logic          o_busy,
    output t_ctl_cmd      o_ctl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_ctl            = '0;
        o_ctl.fin_status = ST_DONE;
        o_busy           = (r_state != S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.cmd)
                    CMD_INSERT: begin
                        if (!i_stat.ins_ok) begin
                            o_ctl.finish     = 1'b1;
                            o_ctl.fin_status = ST_RANGE;
                            n_state          = S_IDLE;
                        end else if (i_stat.full) begin
                            o_ctl.finish     = 1'b1;
                            o_ctl.fin_status = ST_FULL;
                            n_state          = S_IDLE;
                        end else if (i_stat.no_move_ins) begin
                            n_state = S_PLACE;
                        end else begin
                            o_ctl.init = 1'b1;
                            n_state    = S_MOVE;
                        end
                    end
                    CMD_DELETE: begin
                        if (!i_stat.acc_ok) begin
                            o_ctl.finish     = 1'b1;
                            o_ctl.fin_status = ST_RANGE;
                            n_state          = S_IDLE;
                        end else if (i_stat.no_move_del) begin
                            // Removing the tail entry needs no moves.
                            o_ctl.finish    = 1'b1;
                            o_ctl.count_dec = 1'b1;
                            n_state         = S_IDLE;
                        end else begin
                            o_ctl.init = 1'b1;
                            n_state    = S_MOVE;
                        end
                    end
                    CMD_READ: begin
                        if (!i_stat.acc_ok) begin
                            o_ctl.finish     = 1'b1;
                            o_ctl.fin_status = ST_RANGE;
                            n_state          = S_IDLE;
                        end else begin
                            o_ctl.rd_issue = 1'b1;
                            n_state        = S_RDWAIT;
                        end
                    end
                    default: begin
                        o_ctl.finish     = 1'b1;
                        o_ctl.fin_status = ST_RANGE;
                        n_state          = S_IDLE;
                    end
                endcase
            end
            S_MOVE: begin
                o_ctl.step = 1'b1;
                if (i_stat.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_stat.cmd == CMD_INSERT) begin
                    n_state = S_PLACE;
                end else begin
                    o_ctl.finish    = 1'b1;
                    o_ctl.count_dec = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_PLACE: begin
                o_ctl.place     = 1'b1;
                o_ctl.finish    = 1'b1;
                o_ctl.count_inc = 1'b1;
                n_state         = S_IDLE;
            end
            S_RDWAIT: begin
                o_ctl.finish   = 1'b1;
                o_ctl.fin_read = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_idle_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !(o_ctl.step || o_ctl.place || o_ctl.finish))
        else $error("datapath command issued while idle");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |=> (r_state == S_DECODE))
        else $error("loaded beat not decoded");

endmodule

`default_nettype wire

[rtl/positional_list_insert_delete.sv]
// Top level of the positional list: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// An ordered list of up to CAPACITY signed words with insert, delete and read
// at a 1-based position. A command beat is taken at a rising edge where start
// is high and busy is low; busy stays high until the result beat is shown.
// Each command gives one result beat on o_result, marked by o_done for one
// cycle; the receiver cannot stall it, and a new command may be taken in the
// cycle that the result is shown.
// Refused commands and removal of the tail entry finish straight from decode;
// a read waits for its registered memory read. An insert shifts
// m = length - position + 1 entries up, none when appending, then writes the
// new word; a delete shifts m = length - position entries down. The entry
// memory has one read and one write port: one word moves per cycle, its
// registered read overlapping the write of the word before. Reset empties the
// list by clearing the length; the memory is not cleared, and only written
// entries are ever read.
module positional_list_insert_delete import plid_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_in_item i_item,
    output logic          o_done,
    output t_out_item     o_result
);

    t_ctl_cmd w_ctl;
    t_dp_stat w_stat;

    plid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_busy  (busy),
        .o_ctl   (w_ctl)
    );

    plid_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_ctl    (w_ctl),
        .o_stat   (w_stat),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
